// File: rtl/pru_pkg.sv
// Package for the pixel replicating upscaler: register indexes, field codes,
// limits and the command struct passed from the sequencer to the top level.
// No dependencies.
package pru_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  // Meaning of the input tuser bit.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Largest legal enlargement factor; anything above is treated as zero.
  localparam logic [6:0] SCALE_MAX = 7'd100;

  localparam int SCALE_W = 7;
  localparam int WIDTH_W = 11;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int PIX_W   = 24;

  // Per-beat command from the sequencer.
  typedef struct packed {
    logic       store_we;
    logic       store_re;
    logic       res_v;
    logic       row_end;
    logic [1:0] pad;
    logic       frame_end;
    logic       rejected;
  } pru_cmd_t;

endpackage

// File: rtl/pru_seq.sv
// Replay sequencer of the pixel replicating upscaler: configuration registers,
// column and copy counters, and the per-beat store and result command.
// Depends on pru_pkg.
module pru_seq #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [pru_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       fire,
  input  logic                       action,
  output pru_pkg::pru_cmd_t          cmd,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] store_addr
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW     = (ADDR_W + 1 > pru_pkg::WIDTH_W) ? ADDR_W + 1 : pru_pkg::WIDTH_W;

  logic [pru_pkg::SCALE_W-1:0] scale_r;
  logic [pru_pkg::WIDTH_W-1:0] width_r;
  logic [pru_pkg::COUNT_W-1:0] count_r;

  logic [ADDR_W-1:0]           wcol_r, wcol_nxt;
  logic [ADDR_W-1:0]           rcol_r, rcol_nxt;
  logic [pru_pkg::SCALE_W-1:0] acopy_r, acopy_nxt;
  logic [pru_pkg::SCALE_W-1:0] dcopy_r, dcopy_nxt;
  logic [pru_pkg::COUNT_W-1:0] rows_r, rows_nxt;
  logic                        replay_r, replay_nxt;

  logic [CW-1:0]               width_raw, width_eff, wc_p1, rc_p1;
  logic [pru_pkg::SCALE_W-1:0] scale_eff, s_eff;
  logic [pru_pkg::COUNT_W-1:0] count_eff;
  logic [pru_pkg::COUNT_W:0]   rows_p1;
  logic [3:0]                  pad_prod;
  logic                        last_copy, last_col, last_down, frame_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= pru_pkg::SCALE_W'(1);
      width_r <= pru_pkg::WIDTH_W'(1);
      count_r <= pru_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pru_pkg::REG_SCALE: scale_r <= cfg_wdata[pru_pkg::SCALE_W-1:0];
        pru_pkg::REG_WIDTH: width_r <= cfg_wdata[pru_pkg::WIDTH_W-1:0];
        pru_pkg::REG_COUNT: count_r <= cfg_wdata[pru_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_raw = CW'(width_r);
    if (width_raw == '0) begin
      width_eff = CW'(1);
    end else if (width_raw > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    scale_eff = (scale_r > pru_pkg::SCALE_MAX) ? '0 : scale_r;
    // A zero factor arriving mid-replay acts as a factor of one, so no further copies are made.
    s_eff     = (scale_eff == '0) ? pru_pkg::SCALE_W'(1) : scale_eff;
    count_eff = (count_r == '0) ? pru_pkg::COUNT_W'(1) : count_r;
    wc_p1     = CW'(wcol_r) + CW'(1);
    rc_p1     = CW'(rcol_r) + CW'(1);
    rows_p1   = {1'b0, rows_r} + 17'd1;
    // Row bytes are 3*w*s; the pad to four bytes reduces to (w*s) mod 4.
    pad_prod  = {2'b00, width_eff[1:0]} * {2'b00, s_eff[1:0]};
    last_copy = ({1'b0, acopy_r} + 8'd1) >= {1'b0, s_eff};
    last_down = ({1'b0, dcopy_r} + 8'd1) >= {1'b0, s_eff};
    last_col  = rc_p1 >= width_eff;
    frame_wrap = rows_p1 >= {1'b0, count_eff};
  end

  always_comb begin
    wcol_nxt   = wcol_r;
    rcol_nxt   = rcol_r;
    acopy_nxt  = acopy_r;
    dcopy_nxt  = dcopy_r;
    rows_nxt   = rows_r;
    replay_nxt = replay_r;
    cmd        = '0;
    store_addr = (action == pru_pkg::ACT_PIXEL) ? wcol_r : rcol_r;
    if (fire) begin
      if (action == pru_pkg::ACT_PIXEL) begin
        if (replay_r) begin
          cmd.res_v    = 1'b1;
          cmd.rejected = 1'b1;
        end else begin
          cmd.store_we = 1'b1;
          if (wc_p1 >= width_eff) begin
            wcol_nxt  = '0;
            rcol_nxt  = '0;
            acopy_nxt = '0;
            dcopy_nxt = '0;
            if (scale_eff == '0) begin
              rows_nxt = frame_wrap ? '0 : rows_p1[pru_pkg::COUNT_W-1:0];
            end else begin
              replay_nxt = 1'b1;
            end
          end else begin
            wcol_nxt = wc_p1[ADDR_W-1:0];
          end
        end
      end else if (replay_r) begin
        cmd.res_v    = 1'b1;
        cmd.store_re = 1'b1;
        if (!last_copy) begin
          acopy_nxt = acopy_r + pru_pkg::SCALE_W'(1);
        end else begin
          acopy_nxt = '0;
          if (!last_col) begin
            rcol_nxt = rc_p1[ADDR_W-1:0];
          end else begin
            rcol_nxt    = '0;
            cmd.row_end = 1'b1;
            cmd.pad     = pad_prod[1:0];
            if (!last_down) begin
              dcopy_nxt = dcopy_r + pru_pkg::SCALE_W'(1);
            end else begin
              dcopy_nxt     = '0;
              replay_nxt    = 1'b0;
              cmd.frame_end = frame_wrap;
              rows_nxt      = frame_wrap ? '0 : rows_p1[pru_pkg::COUNT_W-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r   <= '0;
      rcol_r   <= '0;
      acopy_r  <= '0;
      dcopy_r  <= '0;
      rows_r   <= '0;
      replay_r <= 1'b0;
    end else begin
      wcol_r   <= wcol_nxt;
      rcol_r   <= rcol_nxt;
      acopy_r  <= acopy_nxt;
      dcopy_r  <= dcopy_nxt;
      rows_r   <= rows_nxt;
      replay_r <= replay_nxt;
    end
  end

  a_no_rw_same_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.store_we && cmd.store_re))
    else $error("line store written and read on the same beat");

  a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_v |-> fire)
    else $error("result raised without an accepted beat");

  a_write_ends_replay_off: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_we |-> !replay_r)
    else $error("line store written during replay");

endmodule

// File: rtl/pixel_replicating_upscaler.sv
// Top level of the pixel replicating upscaler: input skid stage, line store
// memory and output register around the replay sequencer.
// Depends on pru_pkg and pru_seq.
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_tvalid/in_tready  tdata: blue, green, red; tuser: action
//   out_     out  out_tvalid/tready    tdata: blue, green, red, pad; tlast: row end;
//                                      tuser: frame_end, rejected
//   cfg_     in   cfg_we (no ready)    cfg_index, cfg_wdata
//
// One beat per clock in and out while the output is not stalled. A tick
// reads the line store into a register, so a result appears on the output
// register in the cycle after its beat is accepted. The input skid stage
// keeps in_tready registered, so one beat is still taken while the output
// stalls; holding it drops in_tready. Reset is synchronous and active low;
// the line store has no reset and holds a row only once it is written.
module pixel_replicating_upscaler #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  input  logic        in_tuser,   // [0] action: 0 pixel, 1 tick

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] blue, [15:8] green, [23:16] red,
                                  // [25:24] pad_bytes, [31:26] zero
  output logic        out_tlast,  // row_end
  output logic [1:0]  out_tuser,  // [0] frame_end, [1] rejected

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Skid stage: holds a beat that arrived while the output could not advance.
  logic                      skid_v_r, skid_v_nxt;
  logic [pru_pkg::PIX_W-1:0] skid_data_r;
  logic                      skid_act_r;

  logic                      src_v, src_act, advance, fire;
  logic [pru_pkg::PIX_W-1:0] src_data;

  pru_pkg::pru_cmd_t         cmd;
  logic [ADDR_W-1:0]         store_addr;

  logic [pru_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [pru_pkg::PIX_W-1:0] store_rdata_r;

  logic                      out_v_r;
  logic                      out_last_r, out_frame_r, out_rej_r;
  logic [1:0]                out_pad_r;
  logic [pru_pkg::PIX_W-1:0] out_pix;

  assign in_tready = !skid_v_r;
  assign src_v     = skid_v_r || in_tvalid;
  assign src_data  = skid_v_r ? skid_data_r : in_tdata;
  assign src_act   = skid_v_r ? skid_act_r  : in_tuser;
  // The output register moves when it is empty or being drained.
  assign advance   = !out_v_r || out_tready;
  assign fire      = src_v && advance;

  assign skid_v_nxt = skid_v_r ? !fire : (in_tvalid && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_data_r <= in_tdata;
      skid_act_r  <= in_tuser;
    end
  end

  pru_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fire       (fire),
    .action     (src_act),
    .cmd        (cmd),
    .store_addr (store_addr)
  );

  // Line store. Writes and reads never fall on the same beat, and a read one
  // beat after the closing write of a row sees that write already committed.
  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      line_mem[store_addr] <= src_data;
    end
    if (cmd.store_re) begin
      store_rdata_r <= line_mem[store_addr];
    end
  end

  // Output register. The pixel itself lives in the store read register,
  // which only loads on an accepted tick and so holds through a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= fire && cmd.res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_last_r  <= cmd.row_end;
      out_pad_r   <= cmd.pad;
      out_frame_r <= cmd.frame_end;
      out_rej_r   <= cmd.rejected;
    end
  end

  // A rejected pixel reports zeros in every other field.
  assign out_pix    = out_rej_r ? '0 : store_rdata_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_pad_r, out_pix};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_rej_r, out_frame_r};

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end without row end");

  a_pad_only_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[25:24] == 2'd0))
    else $error("pad bytes outside a row end");

  a_rejected_is_bare: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 32'd0 && !out_tlast && !out_tuser[0]))
    else $error("rejected beat carries data");

endmodule

// File: tb/pixel_replicating_upscaler_tb.sv
// Self-checking testbench for pixel_replicating_upscaler: a directed table of
// beats and register writes, then random phases with idling and back-pressure.
// Depends on pru_pkg and the upscaler RTL.
module pixel_replicating_upscaler_tb;

  localparam int MAX_W         = 1024;
  localparam int ADDR_BITS     = $clog2(MAX_W);
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  // Random phases. Most use small rows; a few pin registers at an extreme.
  localparam int NUM_PHASES       = 14;
  localparam int SCALE100_PHASE   = 2;
  localparam int ZERO_SCALE_PHASE = 5;
  localparam int ZERO_WIDTH_PHASE = 6;
  localparam int LARGE_PHASE      = 9;
  localparam int PRESSURE_PHASE   = 12;

  // Kinds of row in the directed table.
  localparam logic [1:0] STEP_BEAT  = 2'd0;  // beat checked by the predictor
  localparam logic [1:0] STEP_KNOWN = 2'd1;  // beat with its result typed in
  localparam logic [1:0] STEP_CFG   = 2'd2;  // register write while idle

  // Idling modes, picked per phase.
  localparam int MODE_NONE      = 0;
  localparam int MODE_SRC_IDLE  = 1;
  localparam int MODE_SNK_STALL = 2;
  localparam int MODE_BOTH      = 3;

  // One result beat, unpacked into its fields.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad;
    logic       frame_end;
    logic       rejected;
  } upscale_beat_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic          act;
    logic [1:0]    idx;
    logic [23:0]   data;  // pixel for beats, register value for writes
    upscale_beat_t res;
  } stim_row_t;

  // Every input of the block has a known value from time zero.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [7:0] blue, [15:8] green, [23:16] red
  logic        in_tuser   = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [7:0] blue, [15:8] green, [23:16] red, [25:24] pad
  logic        out_tlast;         // row end
  logic [1:0]  out_tuser;         // [0] frame_end, [1] rejected
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;

  pixel_replicating_upscaler #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the line store, the replay counters
  // and the three registers as last written.
  logic [23:0]   row_mem [0:MAX_W-1];
  int unsigned   wr_col, rd_col, across_n, down_n, rows_n;
  bit            replay_on;
  logic [6:0]    scale_reg;
  logic [10:0]   width_reg;
  logic [15:0]   count_reg;

  upscale_beat_t expected_q[$];
  int            fail_count    = 0;
  int unsigned   cycle_cnt     = 0;
  int            src_idle_pct  = 0;
  int            snk_stall_pct = 0;
  int            hold_requests = 0;
  int            hold_served   = 0;
  int            hold_left     = 0;

  // Register values as the block interprets them: a factor above the legal
  // maximum means zero, widths clamp into 1..MAX_W, and a zero count means 1.
  function automatic int unsigned scale_eff(logic [6:0] v);
    return (v > pru_pkg::SCALE_MAX) ? 0 : 32'(v);
  endfunction

  function automatic int unsigned width_eff(logic [10:0] v);
    if (v == '0)
      return 1;
    return (32'(v) > MAX_W) ? MAX_W : 32'(v);
  endfunction

  function automatic int unsigned count_eff(logic [15:0] v);
    return (v == '0) ? 1 : 32'(v);
  endfunction

  function automatic void close_row();
    rows_n++;
    if (rows_n >= count_eff(count_reg))
      rows_n = 0;
  endfunction

  // Advances the predictor by one accepted beat and tells whether the beat
  // produces a result, and which.
  task automatic predict_upscale(input logic act, input logic [23:0] pix,
                                 output bit has_res, output upscale_beat_t res);
    int unsigned w, sc, s, idx, bytes;
    logic [31:0] pad_calc;
    logic [23:0] p;
    w       = width_eff(width_reg);
    sc      = scale_eff(scale_reg);
    res     = '0;
    has_res = 1'b0;
    if (act == pru_pkg::ACT_PIXEL) begin
      if (replay_on) begin
        // A pixel arriving during replay is dropped and flagged.
        res.rejected = 1'b1;
        has_res      = 1'b1;
      end else begin
        if (wr_col < MAX_W)
          row_mem[ADDR_BITS'(wr_col)] = pix;
        wr_col++;
        if (wr_col >= w) begin
          wr_col   = 0;
          rd_col   = 0;
          across_n = 0;
          down_n   = 0;
          // With a zero factor the row is swallowed but still counted.
          if (sc == 0)
            close_row();
          else
            replay_on = 1'b1;
        end
      end
    end else if (replay_on) begin
      has_res   = 1'b1;
      idx       = (rd_col < MAX_W) ? rd_col : MAX_W - 1;
      p         = row_mem[ADDR_BITS'(idx)];
      // A factor that drops to zero mid-replay acts as one: no further copies are made.
      s         = (sc == 0) ? 1 : sc;
      res.blue  = p[7:0];
      res.green = p[15:8];
      res.red   = p[23:16];
      if (across_n + 1 < s) begin
        across_n++;
      end else begin
        across_n = 0;
        if (rd_col + 1 < w) begin
          rd_col++;
        end else begin
          rd_col      = 0;
          res.row_end = 1'b1;
          bytes       = 3 * w * s;
          pad_calc    = 4 - (bytes % 4);
          res.pad     = pad_calc[1:0];
          if (down_n + 1 < s) begin
            down_n++;
          end else begin
            down_n    = 0;
            replay_on = 1'b0;
            if (rows_n + 1 >= count_eff(count_reg))
              res.frame_end = 1'b1;
            close_row();
          end
        end
      end
    end
  endtask

  function automatic stim_row_t mk_row(logic [1:0] kind, logic act, logic [1:0] idx,
                                       logic [23:0] data, upscale_beat_t res);
    stim_row_t r;
    r.kind = kind;
    r.act  = act;
    r.idx  = idx;
    r.data = data;
    r.res  = res;
    return r;
  endfunction

  // Offers one input beat, with random idle cycles ahead of it, and holds it
  // until the block takes it. Ready is sampled at the falling edge, where it
  // is settled for the rising edge that follows. The valid line is written
  // once per time step: it is lowered only when an idle cycle comes next.
  task automatic send_beat(input logic act, input logic [23:0] data,
                           input bit use_known, input upscale_beat_t known);
    bit            took;
    bit            has_res;
    upscale_beat_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    predict_upscale(act, data, has_res, res);
    if (use_known)
      expected_q.push_back(known);
    else if (has_res)
      expected_q.push_back(res);
  endtask

  // Writes one register and updates the predictor's copy at the same edge.
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      pru_pkg::REG_SCALE: scale_reg = val[6:0];
      pru_pkg::REG_WIDTH: width_reg = val[10:0];
      pru_pkg::REG_COUNT: count_reg = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering beats, waits for every expected result, then lets a few
  // more cycles pass so that a pixel beat still inside the block, which gives
  // no result, has been consumed before a register changes.
  task automatic drain_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result monitor. Valid and ready are both settled at the falling edge, so
  // a beat seen here is the one taken at the next rising edge.
  always @(negedge clk) begin : result_monitor
    upscale_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.blue      = out_tdata[7:0];
      got.green     = out_tdata[15:8];
      got.red       = out_tdata[23:16];
      got.pad       = out_tdata[25:24];
      got.row_end   = out_tlast;
      got.frame_end = out_tuser[0];
      got.rejected  = out_tuser[1];
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with no expectation, actual 0x%0h", $time, got);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("blue", 32'(want.blue), 32'(got.blue));
        check_field("green", 32'(want.green), 32'(got.green));
        check_field("red", 32'(want.red), 32'(got.red));
        check_field("row_end", 32'(want.row_end), 32'(got.row_end));
        check_field("pad_bytes", 32'(want.pad), 32'(got.pad));
        check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
        check_field("rejected", 32'(want.rejected), 32'(got.rejected));
      end
    end
  end

  // Receiver. A hold-off request from the stimulus drops ready for a long
  // stretch, counted here, so that the output and then the input stage fill
  // up while the sender keeps offering beats.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t     dir_q[$];
    upscale_beat_t rej_only, black_px, white_px;
    int            budget, n, roll;
    logic          act;
    bit            counted;
    logic [31:0]   junk;
    logic [6:0]    sc;
    logic [10:0]   wd;
    logic [15:0]   rc;

    // Predictor state after reset: all counters clear, registers at 1.
    replay_on = 1'b0;
    wr_col    = 0;
    rd_col    = 0;
    across_n  = 0;
    down_n    = 0;
    rows_n    = 0;
    scale_reg = 7'd1;
    width_reg = 11'd1;
    count_reg = 16'd1;

    // Results that follow from the reset settings at a glance: one pixel per
    // row and frame, so every replayed beat ends both, with one pad byte.
    rej_only           = '0;
    rej_only.rejected  = 1'b1;
    black_px           = '0;
    black_px.row_end   = 1'b1;
    black_px.pad       = 2'd1;
    black_px.frame_end = 1'b1;
    white_px           = black_px;
    white_px.blue      = 8'hff;
    white_px.green     = 8'hff;
    white_px.red       = 8'hff;

    // Directed table. A tick with nothing stored is ignored; the first pixel
    // starts a replay, so the next pixel is rejected.
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'h000000, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'h000000, '0));
    dir_q.push_back(mk_row(STEP_KNOWN, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'hffffff,
                           rej_only));
    dir_q.push_back(mk_row(STEP_KNOWN, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'h000000,
                           black_px));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'hffffff, '0));
    dir_q.push_back(mk_row(STEP_KNOWN, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'h000000,
                           white_px));
    // Factor 2 over a two-row frame: four beats per row, frame end at the last.
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'd2, '0));
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_COUNT, 24'd2, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'ha55ac3, '0));
    repeat (4)
      dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'h5aa53c, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'h3c960f, '0));
    repeat (4)
      dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'hc369f0, '0));
    // A zero factor swallows the row; the tick after it is ignored.
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'd0, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'h123456, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'h000000, '0));
    // All-ones written to the factor reads as 127, above the maximum, so
    // zero; a zero width reads as 1 and a zero row count as 1.
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'h00ffff, '0));
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_WIDTH, 24'd0, '0));
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_COUNT, 24'd0, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'h654321, '0));
    // Factor 3, two ticks into the replay, then the factor drops to 1: the
    // copy counter is past the new limit, so the next tick ends the frame.
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'd3, '0));
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_WIDTH, 24'd1, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'h010204, '0));
    repeat (2)
      dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'hfefdfb, '0));
    dir_q.push_back(mk_row(STEP_CFG, pru_pkg::ACT_PIXEL, pru_pkg::REG_SCALE, 24'd1, '0));
    dir_q.push_back(mk_row(STEP_BEAT, pru_pkg::ACT_TICK, pru_pkg::REG_SCALE, 24'h800001, '0));

    // Single reset at the start of the run.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_q[i]) begin
      case (dir_q[i].kind)
        STEP_CFG: begin
          drain_idle();
          cfg_write(dir_q[i].idx, dir_q[i].data[15:0]);
        end
        STEP_KNOWN: send_beat(dir_q[i].act, dir_q[i].data, 1'b1, dir_q[i].res);
        default:    send_beat(dir_q[i].act, dir_q[i].data, 1'b0, '0);
      endcase
    end

    // Random phases. Each one writes all three registers while the block is
    // idle, although the replay itself may be half done; the factor and the
    // row count may then change freely, but the width is not allowed to grow
    // past the stored row, since that would replay entries never written.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      junk = 32'd0;
      case (ph)
        0: begin
          sc = 7'd1;
          wd = 11'd1;
          rc = 16'd1;
        end
        SCALE100_PHASE: begin
          sc = pru_pkg::SCALE_MAX;
          wd = 11'd1;
          rc = 16'hffff;
        end
        ZERO_SCALE_PHASE: begin
          sc = 7'($urandom_range(101, 127));
          wd = 11'($urandom_range(2, 6));
          rc = 16'd0;
        end
        ZERO_WIDTH_PHASE: begin
          sc = 7'd0;
          wd = 11'd0;
          rc = 16'($urandom_range(1, 3));
        end
        LARGE_PHASE: begin
          sc = 7'd1;
          wd = $urandom_range(0, 1) ? 11'd1024 : 11'h7ff;
          rc = 16'd1;
        end
        PRESSURE_PHASE: begin
          sc = 7'd4;
          wd = 11'd8;
          rc = 16'd2;
        end
        default: begin
          // Upper bits of the write data beyond each register are junk.
          junk = $urandom();
          sc   = 7'($urandom_range(1, 4));
          wd   = 11'($urandom_range(1, 8));
          rc   = 16'($urandom_range(1, 4));
        end
      endcase

      // The full-width row must start from a finished replay.
      if (ph == LARGE_PHASE)
        while (replay_on)
          send_beat(pru_pkg::ACT_TICK, 24'($urandom()), 1'b0, '0);

      drain_idle();
      if (replay_on && width_eff(wd) > width_eff(width_reg))
        wd = width_reg;
      cfg_write(pru_pkg::REG_SCALE, {junk[8:0], sc});
      cfg_write(pru_pkg::REG_WIDTH, {junk[13:9], wd});
      cfg_write(pru_pkg::REG_COUNT, rc);

      case (ph % 4)
        MODE_NONE: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        MODE_SRC_IDLE: begin
          src_idle_pct  = 61;
          snk_stall_pct = 0;
        end
        MODE_SNK_STALL: begin
          src_idle_pct  = 0;
          snk_stall_pct = 61;
        end
        default: begin
          src_idle_pct  = 25;
          snk_stall_pct = 25;
        end
      endcase
      if (ph == PRESSURE_PHASE)
        hold_requests++;

      // Mostly well-formed traffic: pixels while a row is being collected,
      // ticks while it replays. The rest is stray ticks and stray pixels.
      // Ticks that the block ignores are not counted against the budget.
      // The wide phase stops partway into its row; the next phase narrows
      // the width, so the first pixel after it closes that row.
      budget = (ph == LARGE_PHASE) ? 150 : $urandom_range(55, 85);
      n      = 0;
      while (n < budget) begin
        roll = $urandom_range(0, 99);
        if (roll < 80)
          act = replay_on ? pru_pkg::ACT_TICK : pru_pkg::ACT_PIXEL;
        else
          act = (roll < 90) ? pru_pkg::ACT_TICK : pru_pkg::ACT_PIXEL;
        counted = !(act == pru_pkg::ACT_TICK && !replay_on);
        send_beat(act, 24'($urandom()), 1'b0, '0);
        if (counted)
          n++;
      end
    end

    drain_idle();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
rtl/pru_pkg.sv
rtl/pru_seq.sv
rtl/pixel_replicating_upscaler.sv
tb/pixel_replicating_upscaler_tb.sv
